// ===== design/arp_neighbor_cache_defines.svh =====
// assertion helpers used by the arp cache controller
`ifndef ARP_NEIGHBOR_CACHE_DEFINES_SVH
`define ARP_NEIGHBOR_CACHE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ANC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arp cache check failed");

// next-cycle implication, sampled on clk, off during rst
`define ANC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arp cache check failed");

`endif

// ===== design/anc_pkg.sv =====
`timescale 1ns / 1ps
package anc_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_OWN_IP     = 2'd0;
  localparam logic [1:0] CFG_IFACE_UP   = 2'd1;
  localparam logic [1:0] CFG_ENTRY_TTL  = 2'd2;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd28;
  localparam logic [15:0] HW_TYPE_ETH   = 16'd1;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'd1;
  localparam logic [15:0] OP_REPLY      = 16'd2;
  localparam logic [31:0] TTL_RESET     = 32'd600000;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

  // search state handed from cell to cell
  typedef struct packed {
    logic        live;
    logic [31:0] key;
    logic        found;
    logic [47:0] mac;
    logic        free;
    logic [31:0] old_time;
  } scan_pkt_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        tick;
    logic        flush;
    logic        wr;
    logic [31:0] now;
    logic [31:0] ttl;
    logic [31:0] wr_ip;
    logic [47:0] wr_mac;
  } cell_ctl_t;

endpackage

// ===== design/arp_neighbor_cache.sv =====
`timescale 1ns / 1ps
// ARP neighbor cache: ENTRIES IPv4-to-MAC entries, one per cell in a row of cells. A lookup or
// received-frame request sends a search packet down the row, one cell per clock, so the row
// length sets how long it takes: the packet goes from the registered head through each cell's
// register, then the SCAN, DECIDE and DELIVER states load the result into the output register.
// An aging tick or flush acts on all cells at once and returns its all-zero result from DELIVER.
// One request is in work at a time and the next is taken only back in IDLE; a finished result
// sits in the output register, so the next request is taken while it waits. Configuration writes
// are always taken (cfg_ready stays high) and must only come while the block is idle.
module arp_neighbor_cache #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   command,
  input  logic [31:0]  now_ms,
  input  logic [31:0]  subject_ip,
  input  logic [47:0]  subject_mac,
  input  logic [31:0]  dest_ip,
  input  logic [15:0]  arp_op,
  input  logic [15:0]  hw_type,
  input  logic [15:0]  proto_type,
  input  logic [7:0]   hw_len,
  input  logic [7:0]   proto_len,
  input  logic [15:0]  frame_len,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         hit,
  output logic [47:0]  found_mac,
  output logic         frame_dropped,
  output logic         sender_resolved,
  output logic         learned,
  output logic         reply_due,
  output logic [47:0]  reply_mac,
  output logic [31:0]  reply_ip,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import anc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] wr_slot;
  scan_pkt_t        pkt       [ENTRIES+1];
  logic [IDX_W-1:0] match_idx [ENTRIES+1];
  logic [IDX_W-1:0] free_idx  [ENTRIES+1];
  logic [IDX_W-1:0] old_idx   [ENTRIES+1];

  assign match_idx[0] = '0;
  assign free_idx[0]  = '0;
  assign old_idx[0]   = '0;

  anc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .now_ms          (now_ms),
    .subject_ip      (subject_ip),
    .subject_mac     (subject_mac),
    .dest_ip         (dest_ip),
    .arp_op          (arp_op),
    .hw_type         (hw_type),
    .proto_type      (proto_type),
    .hw_len          (hw_len),
    .proto_len       (proto_len),
    .frame_len       (frame_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .found_mac       (found_mac),
    .frame_dropped   (frame_dropped),
    .sender_resolved (sender_resolved),
    .learned         (learned),
    .reply_due       (reply_due),
    .reply_mac       (reply_mac),
    .reply_ip        (reply_ip),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctl             (ctl),
    .wr_slot         (wr_slot),
    .head            (pkt[0]),
    .tail            (pkt[ENTRIES]),
    .tail_match_idx  (match_idx[ENTRIES]),
    .tail_free_idx   (free_idx[ENTRIES]),
    .tail_old_idx    (old_idx[ENTRIES])
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    anc_cell #(.ENTRIES(ENTRIES), .CELL_IDX(g)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .wr_slot       (wr_slot),
      .pkt_in        (pkt[g]),
      .match_idx_in  (match_idx[g]),
      .free_idx_in   (free_idx[g]),
      .old_idx_in    (old_idx[g]),
      .pkt_out       (pkt[g+1]),
      .match_idx_out (match_idx[g+1]),
      .free_idx_out  (free_idx[g+1]),
      .old_idx_out   (old_idx[g+1])
    );
  end

endmodule

// ===== design/anc_cell.sv =====
`timescale 1ns / 1ps
module anc_cell #(
  parameter int ENTRIES = 16,
  parameter int CELL_IDX = 0,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  anc_pkg::cell_ctl_t   ctl,
  input  logic [IDX_W-1:0]     wr_slot,
  input  anc_pkg::scan_pkt_t   pkt_in,
  input  logic [IDX_W-1:0]     match_idx_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  input  logic [IDX_W-1:0]     old_idx_in,
  output anc_pkg::scan_pkt_t   pkt_out,
  output logic [IDX_W-1:0]     match_idx_out,
  output logic [IDX_W-1:0]     free_idx_out,
  output logic [IDX_W-1:0]     old_idx_out
);
  import anc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        entry_valid;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic [31:0] entry_time;

  logic        sel;
  logic [31:0] age;
  scan_pkt_t   pkt_next;
  logic [IDX_W-1:0] match_idx_next, free_idx_next, old_idx_next;

  assign sel = ctl.wr && (wr_slot == MY_IDX);
  assign age = ctl.now - entry_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (ctl.flush) begin
      entry_valid <= 1'b0;
    end else if (ctl.tick && entry_valid && (age > ctl.ttl)) begin
      entry_valid <= 1'b0;
    end else if (sel) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      entry_ip   <= ctl.wr_ip;
      entry_mac  <= ctl.wr_mac;
      entry_time <= ctl.now;
    end
  end

  always_comb begin
    pkt_next       = pkt_in;
    match_idx_next = match_idx_in;
    free_idx_next  = free_idx_in;
    old_idx_next   = old_idx_in;
    if (!pkt_in.found && entry_valid && (entry_ip == pkt_in.key)) begin
      pkt_next.found = 1'b1;
      pkt_next.mac   = entry_mac;
      match_idx_next = MY_IDX;
    end
    if (!pkt_in.free && !entry_valid) begin
      pkt_next.free = 1'b1;
      free_idx_next = MY_IDX;
    end
    // strict compare keeps the lowest index on equal times
    if (entry_valid && (entry_time < pkt_in.old_time)) begin
      pkt_next.old_time = entry_time;
      old_idx_next      = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.live <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_out <= match_idx_next;
    free_idx_out  <= free_idx_next;
    old_idx_out   <= old_idx_next;
  end

endmodule

// ===== design/anc_ctrl.sv =====
`timescale 1ns / 1ps
`include "arp_neighbor_cache_defines.svh"
module anc_ctrl #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [31:0]          now_ms,
  input  logic [31:0]          subject_ip,
  input  logic [47:0]          subject_mac,
  input  logic [31:0]          dest_ip,
  input  logic [15:0]          arp_op,
  input  logic [15:0]          hw_type,
  input  logic [15:0]          proto_type,
  input  logic [7:0]           hw_len,
  input  logic [7:0]           proto_len,
  input  logic [15:0]          frame_len,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [47:0]          found_mac,
  output logic                 frame_dropped,
  output logic                 sender_resolved,
  output logic                 learned,
  output logic                 reply_due,
  output logic [47:0]          reply_mac,
  output logic [31:0]          reply_ip,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output anc_pkg::cell_ctl_t   ctl,
  output logic [IDX_W-1:0]     wr_slot,
  output anc_pkg::scan_pkt_t   head,
  input  anc_pkg::scan_pkt_t   tail,
  input  logic [IDX_W-1:0]     tail_match_idx,
  input  logic [IDX_W-1:0]     tail_free_idx,
  input  logic [IDX_W-1:0]     tail_old_idx
);
  import anc_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, DECIDE, DELIVER} state_t;

  state_t state;

  logic [31:0] own_ip;
  logic        iface_up;
  logic [31:0] ttl;

  cmd_t        it_cmd;
  logic [31:0] it_now;
  logic [31:0] it_sip;
  logic [47:0] it_smac;
  logic [31:0] it_tip;
  logic [15:0] it_op;
  logic        it_bad;

  logic        sc_found;
  logic [47:0] sc_mac;
  logic [IDX_W-1:0] sc_slot;

  logic        tick_pulse, flush_pulse, wr_pulse;
  logic [31:0] op_now;
  logic [31:0] wr_ip;
  logic [47:0] wr_mac;

  logic        res_hit, res_dropped, res_resolved, res_learned, res_reply;
  logic [47:0] res_fmac, res_rmac;
  logic [31:0] res_rip;

  logic        res_hit_next, res_dropped_next, res_resolved_next;
  logic        res_learned_next, res_reply_next;
  logic [47:0] res_fmac_next, res_rmac_next;
  logic [31:0] res_rip_next;

  logic        hdr_bad;

  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;

  assign hdr_bad = (frame_len < MIN_FRAME_LEN) || (hw_type != HW_TYPE_ETH) ||
                   (proto_type != PROTO_IPV4) || (hw_len != HW_ADDR_LEN) ||
                   (proto_len != PROTO_ADDR_LEN);

  always_comb begin
    ctl.tick   = tick_pulse;
    ctl.flush  = flush_pulse;
    ctl.wr     = wr_pulse;
    ctl.now    = op_now;
    ctl.ttl    = ttl;
    ctl.wr_ip  = wr_ip;
    ctl.wr_mac = wr_mac;
  end

  always_comb begin
    res_hit_next      = 1'b0;
    res_fmac_next     = '0;
    res_dropped_next  = 1'b0;
    res_resolved_next = 1'b0;
    res_learned_next  = 1'b0;
    res_reply_next    = 1'b0;
    res_rmac_next     = '0;
    res_rip_next      = '0;
    case (it_cmd)
      CMD_LOOKUP: begin
        res_hit_next  = sc_found;
        res_fmac_next = sc_found ? sc_mac : 48'd0;
      end
      CMD_FRAME: begin
        if (it_bad) begin
          res_dropped_next = 1'b1;
        end else begin
          res_resolved_next = (it_sip != 32'd0);
          res_learned_next  = (it_sip != 32'd0) &&
                              ((it_op == OP_REPLY) || (it_tip == own_ip) || sc_found);
          if ((it_op == OP_REQUEST) && iface_up && (it_tip == own_ip)) begin
            res_reply_next = 1'b1;
            res_rmac_next  = it_smac;
            res_rip_next   = it_sip;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      head.live   <= 1'b0;
      tick_pulse  <= 1'b0;
      flush_pulse <= 1'b0;
      wr_pulse    <= 1'b0;
      own_ip      <= 32'd0;
      iface_up    <= 1'b0;
      ttl         <= TTL_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OWN_IP:    own_ip   <= cfg_data;
          CFG_IFACE_UP:  iface_up <= cfg_data[0];
          CFG_ENTRY_TTL: ttl      <= cfg_data;
          default: ;
        endcase
      end

      // a delivering state reloads the output itself
      if (out_valid && !out_stall && (state != DELIVER)) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            it_cmd  <= cmd_t'(command);
            it_now  <= now_ms;
            it_sip  <= subject_ip;
            it_smac <= subject_mac;
            it_tip  <= dest_ip;
            it_op   <= arp_op;
            it_bad  <= hdr_bad;
            op_now  <= now_ms;
            case (cmd_t'(command))
              CMD_LOOKUP, CMD_FRAME: begin
                head.live     <= 1'b1;
                head.key      <= subject_ip;
                head.found    <= 1'b0;
                head.mac      <= '0;
                head.free     <= 1'b0;
                head.old_time <= TIME_MAX;
                state         <= SCAN;
              end
              CMD_TICK: begin
                tick_pulse <= 1'b1;
                state      <= DELIVER;
              end
              default: begin
                flush_pulse <= 1'b1;
                state       <= DELIVER;
              end
            endcase
            res_hit      <= 1'b0;
            res_fmac     <= '0;
            res_dropped  <= 1'b0;
            res_resolved <= 1'b0;
            res_learned  <= 1'b0;
            res_reply    <= 1'b0;
            res_rmac     <= '0;
            res_rip      <= '0;
          end
        end
        SCAN: begin
          head.live <= 1'b0;
          if (tail.live) begin
            sc_found <= tail.found;
            sc_mac   <= tail.mac;
            // existing match, else first free slot, else oldest
            if (tail.found) begin
              sc_slot <= tail_match_idx;
            end else if (tail.free) begin
              sc_slot <= tail_free_idx;
            end else begin
              sc_slot <= tail_old_idx;
            end
            state <= DECIDE;
          end
        end
        DECIDE: begin
          res_hit      <= res_hit_next;
          res_fmac     <= res_fmac_next;
          res_dropped  <= res_dropped_next;
          res_resolved <= res_resolved_next;
          res_learned  <= res_learned_next;
          res_reply    <= res_reply_next;
          res_rmac     <= res_rmac_next;
          res_rip      <= res_rip_next;
          wr_pulse     <= res_learned_next;
          wr_slot      <= sc_slot;
          wr_ip        <= it_sip;
          wr_mac       <= it_smac;
          op_now       <= it_now;
          state        <= DELIVER;
        end
        DELIVER: begin
          tick_pulse  <= 1'b0;
          flush_pulse <= 1'b0;
          wr_pulse    <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            hit             <= res_hit;
            found_mac       <= res_fmac;
            frame_dropped   <= res_dropped;
            sender_resolved <= res_resolved;
            learned         <= res_learned;
            reply_due       <= res_reply;
            reply_mac       <= res_rmac;
            reply_ip        <= res_rip;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ANC_ASSERT_NOW(a_tail_only_in_scan, tail.live, state == SCAN)
  `ANC_ASSERT_NOW(a_write_chain_quiet, wr_pulse, !head.live && !tail.live)
  `ANC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != IDLE)
  `ANC_ASSERT_NOW(a_one_table_op, tick_pulse || flush_pulse, !wr_pulse && !head.live)

endmodule
